>>> hdl/pphe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphe_pkg
// Types and constants shared by the parallel-port handshake engine modules.
// ----------------------------------------------------------------------------
package pphe_pkg;

   localparam int unsigned BYTE_WAIT_W = 22;
   localparam int unsigned SYNC_POLL_W = 16;
   localparam int unsigned SYNC_TRY_W  = 6;

   localparam logic [BYTE_WAIT_W-1:0] BYTE_WAIT_RESET = 22'h300000;
   localparam logic [SYNC_POLL_W-1:0] SYNC_POLL_RESET = 16'd8192;
   localparam logic [SYNC_TRY_W-1:0]  SYNC_TRY_RESET  = 6'd32;

   localparam logic [1:0] CSR_BYTE_WAIT = 2'd0;
   localparam logic [1:0] CSR_SYNC_POLL = 2'd1;
   localparam logic [1:0] CSR_SYNC_TRY  = 2'd2;

   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_SEND  = 3'd1;
   localparam logic [2:0] FUNC_RECV  = 3'd2;
   localparam logic [2:0] FUNC_SYNC  = 3'd3;
   localparam logic [2:0] FUNC_CHECK = 3'd4;

   localparam logic [1:0] OUT_NONE = 2'd0;
   localparam logic [1:0] OUT_DONE = 2'd1;
   localparam logic [1:0] OUT_FAIL = 2'd2;

   localparam logic [3:0] CTRL_REST   = 4'd4;
   localparam logic [3:0] CTRL_STROBE = 4'd5;
   localparam logic [3:0] CTRL_SELECT = 4'd0;

   localparam logic [7:0] DATA_ZERO   = 8'h00;
   localparam logic [7:0] DATA_RX_REQ = 8'h80;
   localparam logic [7:0] DATA_SYNC_A = 8'haa;
   localparam logic [7:0] DATA_SYNC_B = 8'h55;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SEND_LO,
      PH_SEND_HI,
      PH_RX_HI,
      PH_RX_LO,
      PH_SY0,
      PH_SY1,
      PH_SY2,
      PH_SY3,
      PH_SY4,
      PH_CK1,
      PH_CK2
   } phase_type;

   typedef struct packed {
      logic [BYTE_WAIT_W-1:0] byte_wait_limit;
      logic [SYNC_POLL_W-1:0] sync_poll_limit;
      logic [SYNC_TRY_W-1:0]  sync_tries;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_pins;
      logic [3:0] control_drive;
      logic [7:0] rx_byte;
      logic       ready_res;
      logic [1:0] outcome;
   } result_type;

endpackage

>>> hdl/pphe_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphe_csr
// Configuration registers: wait limits and the sync attempt count.
// ----------------------------------------------------------------------------
module pphe_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [1:0]                        csr_index,
   input  logic [pphe_pkg::BYTE_WAIT_W-1:0] csr_wdata,
   output pphe_pkg::cfg_type                 cfg
);

   pphe_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_wait_limit <= pphe_pkg::BYTE_WAIT_RESET;
         cfg_ff.sync_poll_limit <= pphe_pkg::SYNC_POLL_RESET;
         cfg_ff.sync_tries      <= pphe_pkg::SYNC_TRY_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            pphe_pkg::CSR_BYTE_WAIT: begin
               cfg_ff.byte_wait_limit <= csr_wdata;
            end
            pphe_pkg::CSR_SYNC_POLL: begin
               cfg_ff.sync_poll_limit <= csr_wdata[pphe_pkg::SYNC_POLL_W-1:0];
            end
            pphe_pkg::CSR_SYNC_TRY: begin
               cfg_ff.sync_tries <= csr_wdata[pphe_pkg::SYNC_TRY_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/pphe_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphe_engine
// Handshake state machine: processes one registered poll beat per cycle while
// process is high, updates wait counters and line drives, forms the result beat.
// ----------------------------------------------------------------------------
module pphe_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 process,
   input  logic [2:0]           func,
   input  logic [7:0]           tx_byte,
   input  logic [7:0]           status_pins,
   input  logic [3:0]           control_pins,
   input  pphe_pkg::cfg_type    cfg,
   output pphe_pkg::result_type res
);

   pphe_pkg::phase_type                phase_ff, phase_in, phase_cur;
   logic [pphe_pkg::BYTE_WAIT_W-1:0]   wait_ff, wait_in;
   logic [pphe_pkg::SYNC_POLL_W-1:0]   poll_ff, poll_in;
   logic [pphe_pkg::SYNC_TRY_W-1:0]    try_ff, try_in;
   logic [7:0]                         pend_ff, pend_in;
   logic [7:0]                         rcv_ff, rcv_in;
   logic [7:0]                         data_ff, data_in;
   logic [3:0]                         ctrl_ff, ctrl_in;
   logic [1:0]                         outcome;
   logic                               busy, autofeed, select, met;

   assign busy     = status_pins[7];
   assign autofeed = control_pins[1];
   assign select   = control_pins[3];

   always_comb begin
      phase_cur = phase_ff;
      wait_in   = wait_ff;
      poll_in   = poll_ff;
      try_in    = try_ff;
      pend_in   = pend_ff;
      rcv_in    = rcv_ff;
      data_in   = data_ff;
      ctrl_in   = ctrl_ff;
      outcome   = pphe_pkg::OUT_NONE;
      met       = 1'b0;

      if (phase_ff == pphe_pkg::PH_IDLE) begin
         case (func)
            pphe_pkg::FUNC_SEND: begin
               pend_in   = tx_byte;
               wait_in   = '0;
               phase_cur = control_pins[0] ? pphe_pkg::PH_SEND_HI : pphe_pkg::PH_SEND_LO;
            end
            pphe_pkg::FUNC_RECV: begin
               data_in   = pphe_pkg::DATA_RX_REQ;
               wait_in   = '0;
               phase_cur = pphe_pkg::PH_RX_HI;
            end
            pphe_pkg::FUNC_SYNC: begin
               try_in    = '0;
               data_in   = pphe_pkg::DATA_ZERO;
               ctrl_in   = pphe_pkg::CTRL_REST;
               poll_in   = '0;
               phase_cur = pphe_pkg::PH_SY0;
            end
            pphe_pkg::FUNC_CHECK: begin
               poll_in   = '0;
               phase_cur = pphe_pkg::PH_CK1;
            end
            default: begin
            end
         endcase
      end

      phase_in = phase_cur;

      case (phase_cur)
         pphe_pkg::PH_SEND_LO, pphe_pkg::PH_SEND_HI, pphe_pkg::PH_RX_HI,
         pphe_pkg::PH_RX_LO: begin
            if (phase_cur == pphe_pkg::PH_RX_HI) begin
               met = busy;
            end else if (phase_cur == pphe_pkg::PH_RX_LO) begin
               met = !busy;
            end else begin
               met = (autofeed == (phase_cur == pphe_pkg::PH_SEND_HI));
            end
            if (wait_in >= cfg.byte_wait_limit) begin
               phase_in = pphe_pkg::PH_IDLE;
               outcome  = pphe_pkg::OUT_FAIL;
            end else if (!met) begin
               wait_in = wait_in + 1'b1;
            end else if (phase_cur == pphe_pkg::PH_RX_HI) begin
               pend_in  = {4'b0000, status_pins[6:3]};
               data_in  = pphe_pkg::DATA_ZERO;
               wait_in  = '0;
               phase_in = pphe_pkg::PH_RX_LO;
            end else if (phase_cur == pphe_pkg::PH_RX_LO) begin
               rcv_in   = {status_pins[6:3], pend_in[3:0]};
               data_in  = pphe_pkg::DATA_RX_REQ;
               phase_in = pphe_pkg::PH_IDLE;
               outcome  = pphe_pkg::OUT_DONE;
            end else begin
               data_in  = pend_in;
               ctrl_in  = (phase_cur == pphe_pkg::PH_SEND_LO) ?
                          pphe_pkg::CTRL_STROBE : pphe_pkg::CTRL_REST;
               phase_in = pphe_pkg::PH_IDLE;
               outcome  = pphe_pkg::OUT_DONE;
            end
         end
         pphe_pkg::PH_SY0, pphe_pkg::PH_SY1, pphe_pkg::PH_SY2, pphe_pkg::PH_SY3,
         pphe_pkg::PH_SY4: begin
            met = (phase_cur == pphe_pkg::PH_SY1 || phase_cur == pphe_pkg::PH_SY3) ?
                  select : !select;
            if (poll_in >= cfg.sync_poll_limit) begin
               ctrl_in = pphe_pkg::CTRL_REST;
               try_in  = try_in + 1'b1;
               if (try_in >= cfg.sync_tries) begin
                  phase_in = pphe_pkg::PH_IDLE;
                  outcome  = pphe_pkg::OUT_FAIL;
               end else begin
                  data_in  = pphe_pkg::DATA_ZERO;
                  poll_in  = '0;
                  phase_in = pphe_pkg::PH_SY0;
               end
            end else if (!met) begin
               poll_in = poll_in + 1'b1;
            end else begin
               case (phase_cur)
                  pphe_pkg::PH_SY0: begin
                     data_in  = pphe_pkg::DATA_SYNC_A;
                     ctrl_in  = pphe_pkg::CTRL_SELECT;
                     phase_in = pphe_pkg::PH_SY1;
                  end
                  pphe_pkg::PH_SY1: begin
                     ctrl_in  = pphe_pkg::CTRL_REST;
                     phase_in = pphe_pkg::PH_SY2;
                  end
                  pphe_pkg::PH_SY2: begin
                     data_in  = pphe_pkg::DATA_SYNC_B;
                     ctrl_in  = pphe_pkg::CTRL_SELECT;
                     phase_in = pphe_pkg::PH_SY3;
                  end
                  pphe_pkg::PH_SY3: begin
                     ctrl_in  = pphe_pkg::CTRL_REST;
                     phase_in = pphe_pkg::PH_SY4;
                  end
                  default: begin
                     phase_in = pphe_pkg::PH_IDLE;
                     outcome  = pphe_pkg::OUT_DONE;
                  end
               endcase
            end
         end
         pphe_pkg::PH_CK1, pphe_pkg::PH_CK2: begin
            met = (phase_cur == pphe_pkg::PH_CK1) ?
                  (control_pins[0] == control_pins[1]) : !busy;
            if (poll_in >= cfg.sync_poll_limit) begin
               phase_in = pphe_pkg::PH_IDLE;
               outcome  = pphe_pkg::OUT_FAIL;
            end else if (!met) begin
               poll_in = poll_in + 1'b1;
            end else if (phase_cur == pphe_pkg::PH_CK1) begin
               data_in  = pphe_pkg::DATA_ZERO;
               poll_in  = '0;
               phase_in = pphe_pkg::PH_CK2;
            end else begin
               phase_in = pphe_pkg::PH_IDLE;
               outcome  = pphe_pkg::OUT_DONE;
            end
         end
         default: begin
            phase_in = pphe_pkg::PH_IDLE;
         end
      endcase

      res.data_pins     = data_in;
      res.control_drive = ctrl_in;
      res.rx_byte       = rcv_in;
      res.ready_res     = (phase_in == pphe_pkg::PH_IDLE);
      res.outcome       = outcome;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pphe_pkg::PH_IDLE;
         wait_ff  <= '0;
         poll_ff  <= '0;
         try_ff   <= '0;
         pend_ff  <= '0;
         rcv_ff   <= '0;
         data_ff  <= '0;
         ctrl_ff  <= pphe_pkg::CTRL_REST;
      end else if (process) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         poll_ff  <= poll_in;
         try_ff   <= try_in;
         pend_ff  <= pend_in;
         rcv_ff   <= rcv_in;
         data_ff  <= data_in;
         ctrl_ff  <= ctrl_in;
      end
   end

`ifndef ASSERT_OFF
   a_hold_when_idle_stage: assert property (@(posedge clock) disable iff (reset)
      !process |=> $stable(phase_ff) && $stable(wait_ff) && $stable(poll_ff))
      else $error("engine state changed without a beat");

   a_finish_goes_idle: assert property (@(posedge clock) disable iff (reset)
      process && res.outcome != pphe_pkg::OUT_NONE |=> phase_ff == pphe_pkg::PH_IDLE)
      else $error("finished command did not return to idle");

   a_idle_rx_stable: assert property (@(posedge clock) disable iff (reset)
      process && phase_ff != pphe_pkg::PH_RX_LO |=> $stable(rcv_ff))
      else $error("received byte changed outside the low-nibble wait");
`endif

endmodule

>>> hdl/parallel_port_handshake_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_port_handshake_engine_core
// Host side of a parallel-port link, advanced by one poll beat at a time.
// ----------------------------------------------------------------------------
// Each request beat carries a command code, a byte to send and the sampled
// status and control pins. Every request beat yields exactly one response
// beat with the data and control drive, the last received byte, the idle
// flag and the command outcome. Commands are taken only while idle;
// otherwise the command code is ignored and the beat just polls the pins.
// The request beat is captured in an input register; the engine evaluates it
// and loads the response register once that register is free, and the
// response beat is offered from it. Throughput is one beat per cycle while
// rsp_ready does not hold a waiting response beat.
// A stalled response (rsp_ready low) holds the response register; one more
// request beat is still taken into the input register, after which req_ready
// drops until the response is taken.
// Reset clears the engine to idle with control drive 4 and data 0, and loads
// the default wait limits. Configuration writes take effect on the next edge;
// the user must issue them only while the engine is idle (not enforced here).
// ----------------------------------------------------------------------------
module parallel_port_handshake_engine_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_func,
   input  logic [7:0]                        req_tx_byte,
   input  logic [7:0]                        req_status_pins,
   input  logic [3:0]                        req_control_pins,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_data_pins,
   output logic [3:0]                        rsp_control_drive,
   output logic [7:0]                        rsp_rx_byte,
   output logic                              rsp_ready_res,
   output logic [1:0]                        rsp_outcome,
   input  logic                              csr_write_en,
   input  logic [1:0]                        csr_index,
   input  logic [pphe_pkg::BYTE_WAIT_W-1:0] csr_wdata
);

   logic                 in_valid_ff;
   logic [2:0]           func_ff;
   logic [7:0]           tx_ff;
   logic [7:0]           status_ff;
   logic [3:0]           control_ff;
   logic                 rsp_valid_ff;
   pphe_pkg::result_type rsp_ff;
   pphe_pkg::result_type res;
   pphe_pkg::cfg_type    cfg;
   logic                 out_free;
   logic                 process;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign process   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         func_ff    <= req_func;
         tx_ff      <= req_tx_byte;
         status_ff  <= req_status_pins;
         control_ff <= req_control_pins;
      end
   end

   pphe_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   pphe_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .process      (process),
      .func         (func_ff),
      .tx_byte      (tx_ff),
      .status_pins  (status_ff),
      .control_pins (control_ff),
      .cfg          (cfg),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_pins     = rsp_ff.data_pins;
   assign rsp_control_drive = rsp_ff.control_drive;
   assign rsp_rx_byte       = rsp_ff.rx_byte;
   assign rsp_ready_res     = rsp_ff.ready_res;
   assign rsp_outcome       = rsp_ff.outcome;

`ifndef ASSERT_OFF
   a_beat_reaches_output: assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_valid_ff)
      else $error("processed beat did not reach the response register");

   a_outcome_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.outcome == pphe_pkg::OUT_NONE || rsp_ff.ready_res)
      else $error("outcome reported while the engine is still busy");

   a_full_pipe_blocks_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while both stages are full");
`endif

endmodule
